/* rtl/vvbs_pkg.sv */
`default_nettype none
package vvbs_pkg;

   localparam int Lanes    = 3;
   localparam int DivSteps = 48;   // quotient bits of (net << 16) / mass
   localparam int ProdW    = 66;   // 33 x 33 signed product

   // register indexes of the config port
   localparam logic [1:0] CSR_GRAV_X = 2'd0;
   localparam logic [1:0] CSR_GRAV_Y = 2'd1;
   localparam logic [1:0] CSR_GRAV_Z = 2'd2;

   localparam logic signed [31:0] GravXRst = 32'sd0;
   localparam logic signed [31:0] GravYRst = -32'sd642253;   // about -9.8
   localparam logic signed [31:0] GravZRst = 32'sd0;

   localparam logic signed [31:0] SatMax = 32'sh7fff_ffff;
   localparam logic signed [31:0] SatMin = 32'sh8000_0000;

   typedef struct packed {
      logic [7:0]       idx;
      logic [2:0][31:0] frc;
      logic [30:0]      mass;
      logic             gon;
      logic [15:0]      dt;
   } item_type;

   // one table row holds the whole state of one body
   typedef struct packed {
      logic [2:0][31:0] acc;
      logic [2:0][31:0] vel;
      logic [2:0][31:0] pos;
   } row_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } bk_ctl_type;

   typedef struct packed {
      logic not_empty;
   } q_stat_type;

   function automatic logic signed [31:0] sat32(input logic signed [ProdW-1:0] x);
      logic signed [31:0] r;
      if (x > 66'sd2147483647) r = SatMax;
      else if (x < -66'sd2147483648) r = SatMin;
      else r = $signed(x[31:0]);
      return r;
   endfunction

   // round to nearest, ties toward plus infinity
   function automatic logic signed [ProdW-1:0] rshr(input logic signed [ProdW-1:0] x,
                                                     input int unsigned s);
      logic signed [ProdW-1:0] half;
      half = 66'sd1 <<< (s - 1);
      return (x + half) >>> s;
   endfunction

endpackage
`default_nettype wire

/* rtl/velocity_verlet_body_step_top.sv */
`default_nettype none
// Velocity Verlet step over a table of bodies, signed Q16.16, saturating.
//
// Input channel: drive req_* and raise start; the beat is taken at a
// rising edge where start is high and busy is low. Each beat names a
// body, its applied force, mass, gravity flag and time step.
// Result channel: rsp_valid is high for exactly one cycle per input beat,
// with the body index, new position and new velocity on rsp_*. Results
// come in input order. The receiver cannot stall; it must take each beat.
// Config: csr_write_en with csr_index / csr_wdata writes the gravity
// vector (0 x, 1 y, 2 z); index 3 is ignored. Write only while idle.
//
// Back end: one item at a time, each through the 48-step restoring
// divide of net force by mass, shared by the three axes.
// A two-beat queue lets new items be taken while one is in progress.
//
// Reset: gravity returns to (0, -9.8, 0) and a clearing pass zeroes the
// state table, one body per cycle over all MAX_BODIES rows, with busy high.
module velocity_verlet_body_step_top import vvbs_pkg::*; #(
   parameter int MAX_BODIES = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [7:0]         req_body_index,
   input  wire logic signed [31:0] req_force_x,
   input  wire logic signed [31:0] req_force_y,
   input  wire logic signed [31:0] req_force_z,
   input  wire logic [30:0]        req_body_mass,
   input  wire logic               req_gravity_on,
   input  wire logic [15:0]        req_time_step,
   output logic                    rsp_valid,
   output logic [7:0]              rsp_out_index,
   output logic signed [31:0]      rsp_pos_x,
   output logic signed [31:0]      rsp_pos_y,
   output logic signed [31:0]      rsp_pos_z,
   output logic signed [31:0]      rsp_vel_x,
   output logic signed [31:0]      rsp_vel_y,
   output logic signed [31:0]      rsp_vel_z,
   input  wire logic               csr_write_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);
   localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;

   // gravity vector registers
   logic signed [31:0] grav_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff[0] <= GravXRst;
         grav_ff[1] <= GravYRst;
         grav_ff[2] <= GravZRst;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_GRAV_X: grav_ff[0] <= $signed(csr_wdata);
            CSR_GRAV_Y: grav_ff[1] <= $signed(csr_wdata);
            CSR_GRAV_Z: grav_ff[2] <= $signed(csr_wdata);
            default: ;   // unmapped index, dropped
         endcase
      end
   end

   item_type      item_in, head;
   bk_ctl_type    bk_ctl;
   q_stat_type    q_stat;
   logic [AW-1:0] head_row;
   logic signed [31:0] pos [3], vel [3];

   always_comb begin
      item_in.idx    = req_body_index;
      item_in.frc[0] = req_force_x;
      item_in.frc[1] = req_force_y;
      item_in.frc[2] = req_force_z;
      item_in.mass   = req_body_mass;
      item_in.gon    = req_gravity_on;
      item_in.dt     = req_time_step;
   end

   // front: accept and fold the index, queue two beats
   vvbs_front #(.MAX_BODIES(MAX_BODIES)) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .item_in  (item_in),
      .bk_ctl   (bk_ctl),
      .q_stat   (q_stat),
      .head     (head),
      .head_row (head_row)
   );

   // back: table, multiplies, divide, write back, result register
   vvbs_back #(.MAX_BODIES(MAX_BODIES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .grav      (grav_ff),
      .q_stat    (q_stat),
      .head      (head),
      .head_row  (head_row),
      .bk_ctl    (bk_ctl),
      .rsp_valid (rsp_valid),
      .rsp_idx   (rsp_out_index),
      .rsp_pos   (pos),
      .rsp_vel   (vel)
   );

   assign rsp_pos_x = pos[0];
   assign rsp_pos_y = pos[1];
   assign rsp_pos_z = pos[2];
   assign rsp_vel_x = vel[0];
   assign rsp_vel_y = vel[1];
   assign rsp_vel_z = vel[2];
endmodule
`default_nettype wire

/* rtl/vvbs_ram.sv */
`default_nettype none
module vvbs_ram #(
   parameter int WIDTH = 288,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      if (re) rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

/* rtl/vvbs_div.sv */
`default_nettype none
// three-lane restoring divider, one quotient bit per cycle, shared divisor
module vvbs_div import vvbs_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              go,
   input  wire logic [2:0][31:0]  num_mag,
   input  wire logic [30:0]       divisor,
   output logic                   done,
   output logic [2:0][47:0]       quo
);
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [30:0]      dvs_ff;
   logic [2:0][47:0] nq_ff, nq_in;
   logic [2:0][31:0] rem_ff, rem_in;

   always_comb begin
      logic [32:0] rs;
      logic        ge;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      nq_in   = nq_ff;
      rem_in  = rem_ff;
      rs      = '0;
      ge      = 1'b0;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = 6'(DivSteps - 1);
         for (int c = 0; c < Lanes; c++) begin
            nq_in[c]  = {num_mag[c], 16'b0};
            rem_in[c] = '0;
         end
      end else if (busy_ff) begin
         for (int c = 0; c < Lanes; c++) begin
            rs = {rem_ff[c], nq_ff[c][47]};
            ge = rs >= {2'b0, dvs_ff};
            rem_in[c] = ge ? 32'(rs - {2'b0, dvs_ff}) : rs[31:0];
            nq_in[c]  = {nq_ff[c][46:0], ge};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      if (go) dvs_ff <= divisor;
      nq_ff  <= nq_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quo  = nq_ff;
endmodule
`default_nettype wire

/* rtl/vvbs_front.sv */
`default_nettype none
// takes items, folds the body index onto the table, two-beat queue
module vvbs_front import vvbs_pkg::*; #(
   parameter int MAX_BODIES = 256,
   localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire item_type   item_in,
   input  wire bk_ctl_type bk_ctl,
   output q_stat_type      q_stat,
   output item_type        head,
   output logic [AW-1:0]   head_row
);
   item_type      ent_ff [2];
   logic [AW-1:0] row_ff [2];
   logic          wp_ff, rp_ff;
   logic [1:0]    cnt_ff, cnt_in;
   logic          accept;
   logic [20:0]   red;

   // index modulo MAX_BODIES by shifted compare and subtract
   always_comb begin
      red = {13'b0, item_in.idx};
      for (int k = 7; k >= 0; k--) begin
         if (red >= (21'(MAX_BODIES) << k)) red = red - (21'(MAX_BODIES) << k);
      end
   end

   assign busy   = (cnt_ff == 2'd2) || bk_ctl.clearing;
   assign accept = start && !busy;

   always_comb begin
      cnt_in = cnt_ff;
      if (accept && !bk_ctl.pop) cnt_in = cnt_ff + 2'd1;
      else if (!accept && bk_ctl.pop) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (accept) wp_ff <= !wp_ff;
         if (bk_ctl.pop) rp_ff <= !rp_ff;
      end
      if (accept) begin
         ent_ff[wp_ff] <= item_in;
         row_ff[wp_ff] <= red[AW-1:0];
      end
   end

   assign q_stat.not_empty = cnt_ff != 2'd0;
   assign head             = ent_ff[rp_ff];
   assign head_row         = row_ff[rp_ff];
endmodule
`default_nettype wire

/* rtl/vvbs_back.sv */
`default_nettype none
// sequencer: table read, lane multiplies, divide, write back, result beat
module vvbs_back import vvbs_pkg::*; #(
   parameter int MAX_BODIES = 256,
   localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic signed [31:0] grav [3],
   input  wire q_stat_type         q_stat,
   input  wire item_type           head,
   input  wire logic [AW-1:0]      head_row,
   output bk_ctl_type              bk_ctl,
   output logic                    rsp_valid,
   output logic [7:0]              rsp_idx,
   output logic signed [31:0]      rsp_pos [3],
   output logic signed [31:0]      rsp_vel [3]
);
   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_GM    = 4'd2;
   localparam logic [3:0] ST_VD    = 4'd3;
   localparam logic [3:0] ST_PD    = 4'd4;
   localparam logic [3:0] ST_AD    = 4'd5;
   localparam logic [3:0] ST_VH    = 4'd6;
   localparam logic [3:0] ST_DW    = 4'd7;
   localparam logic [3:0] ST_AN    = 4'd8;
   localparam logic [3:0] ST_FIN   = 4'd9;

   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff;
   item_type      it_ff;
   logic [AW-1:0] row_ff;
   logic [31:0]   dd_ff;
   logic          pop;

   logic signed [ProdW-1:0] pr_ff [3];
   logic signed [ProdW-1:0] pr_in [3];
   logic signed [31:0]      net_ff [3], net_in [3];
   logic signed [32:0]      t1_ff [3], t1_in [3];
   logic signed [31:0]      pn_ff [3], pn_in [3];
   logic signed [31:0]      vh_ff [3], vh_in [3];
   logic signed [31:0]      an_ff [3], an_in [3];
   logic signed [31:0]      vn [3];
   logic signed [32:0]      a_op [3], b_op [3];
   logic signed [31:0]      p_s [3], v_s [3], a_s [3];

   logic                    rsp_valid_ff;
   logic [7:0]              rsp_idx_ff;
   logic signed [31:0]      rsp_pos_ff [3], rsp_vel_ff [3];

   row_type          rdata, wdata;
   logic             we;
   logic [AW-1:0]    waddr;
   logic [2:0][31:0] num_mag;
   logic             div_done;
   logic [2:0][47:0] quo;

   vvbs_ram #(.WIDTH($bits(row_type)), .DEPTH(MAX_BODIES)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (pop),
      .raddr (head_row),
      .rdata (rdata)
   );

   vvbs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .go      (state_ff == ST_PD),
      .num_mag (num_mag),
      .divisor (it_ff.mass),
      .done    (div_done),
      .quo     (quo)
   );

   assign pop             = (state_ff == ST_IDLE) && q_stat.not_empty;
   assign bk_ctl.pop      = pop;
   assign bk_ctl.clearing = state_ff == ST_CLEAR;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == AW'(MAX_BODIES - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (q_stat.not_empty) state_in = ST_GM;
         ST_GM:    state_in = ST_VD;
         ST_VD:    state_in = ST_PD;
         ST_PD:    state_in = ST_AD;
         ST_AD:    state_in = ST_VH;
         ST_VH:    state_in = ST_DW;
         ST_DW:    if (div_done) state_in = ST_AN;
         ST_AN:    state_in = ST_FIN;
         ST_FIN:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // one multiplier per lane, operands picked by step
   always_comb begin
      logic signed [ProdW-1:0] r16, r17, r33;
      logic signed [31:0]      gm;
      logic signed [34:0]      psum;
      logic signed [33:0]      vsum, vsum2;
      logic signed [49:0]      qv, sq;
      r16 = '0; r17 = '0; r33 = '0; gm = '0; psum = '0;
      vsum = '0; vsum2 = '0; qv = '0; sq = '0;
      for (int c = 0; c < Lanes; c++) begin
         p_s[c] = $signed(rdata.pos[c]);
         v_s[c] = $signed(rdata.vel[c]);
         a_s[c] = $signed(rdata.acc[c]);
         unique case (state_ff)
            ST_VD: begin
               a_op[c] = 33'(v_s[c]);
               b_op[c] = $signed({17'b0, it_ff.dt});
            end
            ST_PD: begin
               a_op[c] = 33'(a_s[c]);
               b_op[c] = $signed({1'b0, dd_ff});
            end
            ST_AD: begin
               a_op[c] = 33'(a_s[c]);
               b_op[c] = $signed({17'b0, it_ff.dt});
            end
            ST_AN: begin
               a_op[c] = 33'(an_ff[c]);
               b_op[c] = $signed({17'b0, it_ff.dt});
            end
            default: begin
               a_op[c] = 33'(grav[c]);
               b_op[c] = $signed({2'b0, it_ff.mass});
            end
         endcase
         pr_in[c] = ProdW'(a_op[c]) * ProdW'(b_op[c]);

         r16 = rshr(pr_ff[c], 16);
         r17 = rshr(pr_ff[c], 17);
         r33 = rshr(pr_ff[c], 33);

         gm = sat32(r16);
         net_in[c] = it_ff.gon ? sat32(ProdW'(33'($signed(it_ff.frc[c])) + 33'(gm)))
                               : $signed(it_ff.frc[c]);
         num_mag[c] = net_ff[c][31] ? 32'(-net_ff[c]) : net_ff[c];

         t1_in[c] = $signed(r16[32:0]);
         psum     = 35'(p_s[c]) + 35'(t1_ff[c]) + $signed(r33[34:0]);
         pn_in[c] = sat32(ProdW'(psum));
         vsum     = 34'(v_s[c]) + $signed(r17[33:0]);
         vh_in[c] = sat32(ProdW'(vsum));

         qv = $signed({2'b0, quo[c]});
         sq = net_ff[c][31] ? -qv : qv;
         if (it_ff.mass == 31'd0) begin
            if (net_ff[c] > 32'sd0) an_in[c] = SatMax;
            else if (net_ff[c] < 32'sd0) an_in[c] = SatMin;
            else an_in[c] = 32'sd0;
         end else begin
            an_in[c] = sat32(ProdW'(sq));
         end

         vsum2 = 34'(vh_ff[c]) + $signed(r17[33:0]);
         vn[c] = sat32(ProdW'(vsum2));

         wdata.pos[c] = pn_ff[c];
         wdata.vel[c] = vn[c];
         wdata.acc[c] = an_ff[c];
      end
      if (state_ff == ST_CLEAR) wdata = '0;
   end

   assign we    = (state_ff == ST_CLEAR) || (state_ff == ST_FIN);
   assign waddr = (state_ff == ST_CLEAR) ? clr_ff : row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= state_ff == ST_FIN;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + AW'(1);
      end
      if (pop) begin
         it_ff  <= head;
         row_ff <= head_row;
      end
      if (state_ff == ST_GM) dd_ff <= 32'(it_ff.dt) * 32'(it_ff.dt);
      for (int c = 0; c < Lanes; c++) begin
         pr_ff[c] <= pr_in[c];
         if (state_ff == ST_VD) net_ff[c] <= net_in[c];
         if (state_ff == ST_PD) t1_ff[c] <= t1_in[c];
         if (state_ff == ST_AD) pn_ff[c] <= pn_in[c];
         if (state_ff == ST_VH) vh_ff[c] <= vh_in[c];
         if (state_ff == ST_DW && div_done) an_ff[c] <= an_in[c];
         if (state_ff == ST_FIN) begin
            rsp_pos_ff[c] <= pn_ff[c];
            rsp_vel_ff[c] <= vn[c];
         end
      end
      if (state_ff == ST_FIN) rsp_idx_ff <= it_ff.idx;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_idx   = rsp_idx_ff;
   assign rsp_pos   = rsp_pos_ff;
   assign rsp_vel   = rsp_vel_ff;

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == ST_FIN)
      else $error("result beat without a finished item");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == ST_IDLE && q_stat.not_empty)
      else $error("queue popped outside idle");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DW)
      else $error("divide finished while not waiting for it");

   a_write_src: assert property (@(posedge clock) disable iff (reset)
      we |-> state_ff == ST_CLEAR || state_ff == ST_FIN)
      else $error("table write outside clear or write back");
endmodule
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 100ps
module testbench;
   import vvbs_pkg::*;

   // index 3 of the csr port is unmapped, writes there must be dropped
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;
   localparam int         NumBodies    = 256;

   typedef logic signed [95:0] wide_type;

   typedef struct {
      logic [7:0]         idx;
      logic signed [31:0] pos [3];
      logic signed [31:0] vel [3];
   } body_state_type;

   // ---------------------------------------------------------------
   // Scoreboard: owns a private copy of gravity and the body table,
   // advances it for every accepted beat and queues the expected state.
   // ---------------------------------------------------------------
   class verlet_scoreboard;
      logic signed [31:0] gravity [3];
      logic signed [31:0] pos_tab [NumBodies*3];
      logic signed [31:0] vel_tab [NumBodies*3];
      logic signed [31:0] acc_tab [NumBodies*3];
      body_state_type     pending_states [$];
      int                 errors;
      int                 checked;
      int                 noted;

      function new();
         gravity[0] = GravXRst;
         gravity[1] = GravYRst;
         gravity[2] = GravZRst;
         foreach (pos_tab[i]) begin
            pos_tab[i] = '0;
            vel_tab[i] = '0;
            acc_tab[i] = '0;
         end
         errors  = 0;
         checked = 0;
         noted   = 0;
      endfunction

      function logic signed [31:0] clamp(wide_type x);
         if (x > wide_type'(64'sh7fff_ffff)) return SatMax;
         if (x < -wide_type'(64'sh8000_0000)) return SatMin;
         return x[31:0];
      endfunction

      // nearest, ties toward +inf
      function wide_type round_shift(wide_type x, int s);
         wide_type half;
         half = wide_type'(1) <<< (s - 1);
         return (x + half) >>> s;
      endfunction

      function void write_gravity(logic [1:0] index, logic [31:0] value);
         case (index)
            CSR_GRAV_X: gravity[0] = value;
            CSR_GRAV_Y: gravity[1] = value;
            CSR_GRAV_Z: gravity[2] = value;
            default: ;
         endcase
      endfunction

      function void note_beat(item_type it);
         body_state_type exp;
         wide_type m, d, f, p, v, a, net, an, vh, vn, pn;
         int base;
         m    = $signed({65'd0, it.mass});
         d    = $signed({80'd0, it.dt});
         base = (it.idx % NumBodies) * 3;
         exp.idx = it.idx;
         for (int c = 0; c < 3; c++) begin
            f = $signed(it.frc[c]);
            p = pos_tab[base + c];
            v = vel_tab[base + c];
            a = acc_tab[base + c];
            net = f;
            if (it.gon)
               net = clamp(f + clamp(round_shift(gravity[c] * m, 16)));
            pn = clamp(p + round_shift(v * d, 16) + round_shift(a * d * d, 33));
            vh = clamp(v + round_shift(a * d, 17));
            if (m == 0)
               an = net > 0 ? SatMax : (net < 0 ? SatMin : 0);
            else
               an = clamp((net <<< 16) / m);
            vn = clamp(vh + round_shift(an * d, 17));
            pos_tab[base + c] = pn[31:0];
            vel_tab[base + c] = vn[31:0];
            acc_tab[base + c] = an[31:0];
            exp.pos[c] = pn[31:0];
            exp.vel[c] = vn[31:0];
         end
         pending_states = {pending_states, exp};
         noted++;
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
         errors++;
      endtask

      task check_beat(body_state_type got);
         body_state_type exp;
         checked++;
         if (pending_states.size() == 0) begin
            report("unexpected result beat, index", 32'(got.idx), 32'd0);
            return;
         end
         exp = pending_states.pop_front();
         if (got.idx !== exp.idx) report("out_index", 32'(got.idx), 32'(exp.idx));
         for (int c = 0; c < 3; c++) begin
            if (got.pos[c] !== exp.pos[c]) report($sformatf("pos[%0d]", c), got.pos[c], exp.pos[c]);
            if (got.vel[c] !== exp.vel[c]) report($sformatf("vel[%0d]", c), got.vel[c], exp.vel[c]);
         end
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [7:0]         req_body_index = '0;
   logic signed [31:0] req_force_x = '0;
   logic signed [31:0] req_force_y = '0;
   logic signed [31:0] req_force_z = '0;
   logic [30:0]        req_body_mass = '0;
   logic               req_gravity_on = 1'b0;
   logic [15:0]        req_time_step = '0;
   logic               rsp_valid;
   logic [7:0]         rsp_out_index;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [31:0] rsp_vel_x, rsp_vel_y, rsp_vel_z;
   logic               csr_write_en = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   verlet_scoreboard board = new();
   bit               burst_mode;   // no input gaps while set

   velocity_verlet_body_step_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: the slowest run, ~1800 beats with gaps, ends far below this.
   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

   // Result side cannot stall: every rsp_valid cycle is one beat.
   always @(posedge clock) begin
      body_state_type got;
      if (!reset && rsp_valid) begin
         got.idx    = rsp_out_index;
         got.pos[0] = rsp_pos_x;
         got.pos[1] = rsp_pos_y;
         got.pos[2] = rsp_pos_z;
         got.vel[0] = rsp_vel_x;
         got.vel[1] = rsp_vel_y;
         got.vel[2] = rsp_vel_z;
         board.check_beat(got);
      end
   end

   // mostly short gaps, a few long ones
   function int pick_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 120);
   endfunction

   // Drive one beat and hold start until busy is low at an edge.
   task send_beat(item_type it);
      int gap;
      req_body_index <= it.idx;
      req_force_x    <= it.frc[0];
      req_force_y    <= it.frc[1];
      req_force_z    <= it.frc[2];
      req_body_mass  <= it.mass;
      req_gravity_on <= it.gon;
      req_time_step  <= it.dt;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      board.note_beat(it);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task write_csr(logic [1:0] index, logic [31:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      board.write_gravity(index, value);
      @(posedge clock);
   endtask

   // drop start, drain all results and wait for busy low, so the block is idle for csr writes
   task drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending_states.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3, 4: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   function item_type pick_item(bit hot);
      item_type it;
      it.idx = hot ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
      for (int c = 0; c < 3; c++) it.frc[c] = pick_word();
      case ($urandom_range(0, 49))
         0:        it.mass = '0;          // zero mass path
         1, 2:     it.mass = 31'd1;
         3, 4:     it.mass = 31'h7fff_ffff;
         5, 6, 7:  it.mass = 31'($urandom);
         default:  it.mass = 31'($urandom_range(32'h1000, 32'h0100_0000));
      endcase
      case ($urandom_range(0, 9))
         0:       it.dt = '0;
         1:       it.dt = 16'hffff;
         2, 3, 4: it.dt = 16'($urandom_range(1, 16'h0800));
         default: it.dt = 16'($urandom);
      endcase
      it.gon = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function item_type make_item(logic [7:0] idx, logic [31:0] fx, logic [31:0] fy,
                                logic [31:0] fz, logic [30:0] mass, logic gon,
                                logic [15:0] dt);
      item_type it;
      it.idx = idx;
      it.frc[0] = fx;
      it.frc[1] = fy;
      it.frc[2] = fz;
      it.mass = mass;
      it.gon = gon;
      it.dt = dt;
      return it;
   endfunction

   initial begin
      int phase_items;
      burst_mode = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // clearing pass after reset keeps busy high
      @(posedge clock);
      while (busy) @(posedge clock);

      // Directed: field extremes, gravity on/off, zero mass, zero step, max step.
      send_beat(make_item(8'd0, 32'h0001_0000, 32'h0, 32'h0, 31'h0001_0000, 1'b0, 16'h8000));
      send_beat(make_item(8'd0, 32'h0, 32'h0, 32'h0, 31'h0001_0000, 1'b1, 16'h8000));
      send_beat(make_item(8'd0, 32'h0, 32'h0, 32'h0, 31'h0001_0000, 1'b1, 16'h0));
      send_beat(make_item(8'd255, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 31'd1, 1'b0, 16'hffff));
      send_beat(make_item(8'd255, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 31'd1, 1'b0, 16'hffff));
      send_beat(make_item(8'd255, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 31'h7fff_ffff, 1'b1,
                          16'hffff));
      send_beat(make_item(8'd1, 32'h0005_0000, 32'hfffb_0000, 32'h0, 31'h0, 1'b0, 16'h1000));
      send_beat(make_item(8'd1, 32'h0, 32'h0, 32'h0, 31'h0, 1'b0, 16'h1000));
      send_beat(make_item(8'd1, 32'h0, 32'h0, 32'h0, 31'h0, 1'b1, 16'h1000));
      send_beat(make_item(8'd2, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'd1, 1'b1,
                          16'hffff));
      for (int k = 0; k < 4; k++)
         send_beat(make_item(8'd2, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'd1, 1'b0,
                             16'hffff));
      send_beat(make_item(8'd3, 32'hffff_ffff, 32'h1, 32'h8000, 31'h0000_8000, 1'b0, 16'd1));
      send_beat(make_item(8'd128, 32'h0, 32'h0, 32'h0, 31'h7fff_ffff, 1'b1, 16'hffff));
      drain();

      // Five gravity settings, about 350 random beats each.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: ;   // reset gravity
            1: begin
               write_csr(CSR_GRAV_X, 32'h7fff_ffff);
               write_csr(CSR_GRAV_Y, 32'h8000_0000);
               write_csr(CSR_GRAV_Z, 32'h7fff_ffff);
            end
            2: begin
               write_csr(CSR_GRAV_X, 32'h8000_0000);
               write_csr(CSR_GRAV_Y, 32'h7fff_ffff);
               write_csr(CSR_GRAV_Z, 32'h8000_0000);
               write_csr(CSR_UNMAPPED, $urandom);
            end
            3: begin
               write_csr(CSR_GRAV_X, 32'h0);
               write_csr(CSR_GRAV_Y, 32'h0);
               write_csr(CSR_GRAV_Z, 32'h0);
               write_csr(CSR_UNMAPPED, 32'hffff_ffff);
            end
            default: begin
               write_csr(CSR_GRAV_X, $urandom);
               write_csr(CSR_GRAV_Y, $urandom_range(0, 32'h001f_ffff) - 32'h0010_0000);
               write_csr(CSR_GRAV_Z, $urandom);
            end
         endcase
         phase_items = 350;
         for (int k = 0; k < phase_items; k++) begin
            // stretches of back-to-back beats now and then
            if (k % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            send_beat(pick_item($urandom_range(0, 3) != 0));
         end
         burst_mode = 1'b0;
         drain();
      end

      // tail: let any straggling beat surface
      repeat (100) @(posedge clock);
      $display("covered %0d beats over 5 gravity settings, %0d results checked, %0d mismatches",
               board.noted, board.checked, board.errors);
      $display("leftover expectations: %0d", board.pending_states.size());
      if (board.errors == 0 && board.pending_states.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* files.f */
rtl/vvbs_pkg.sv
rtl/vvbs_ram.sv
rtl/vvbs_div.sv
rtl/vvbs_front.sv
rtl/vvbs_back.sv
rtl/velocity_verlet_body_step_top.sv
sim/testbench.sv
